### rtl/trbe_pkg.sv
// ----------------------------------------------------------------------------
// trbe_pkg
// Shared types and constants of the touch region button event block.
// ----------------------------------------------------------------------------
package trbe_pkg;

  localparam int NUM_BUTTONS_DEF = 4;
  localparam int REGION_REGS     = 4;
  localparam int BTN_IDX_W       = 3;
  localparam int LEVELS_W        = 4;
  localparam int ADDR_W          = 6;
  localparam int DATA_W          = 64;
  localparam int REGION_W        = 64;
  localparam int TICK_W          = 32;
  localparam int COORD_W         = 16;

  localparam int FLAG_PRESS   = 0;
  localparam int FLAG_RELEASE = 1;
  localparam int FLAG_LONG    = 2;

  localparam logic [2:0] REG_ACTIVE = 3'd4;

  typedef enum logic [2:0] {
    OP_SAMPLE  = 3'd0,
    OP_PRESSED = 3'd1,
    OP_RELEASD = 3'd2,
    OP_LONG    = 3'd3,
    OP_LEVEL   = 3'd4
  } op_t;

  typedef struct packed {
    logic step;
    logic active;
    logic sel;
    logic clear;
    op_t  op;
  } btn_ctl_t;

  typedef struct packed {
    logic               down;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [TICK_W-1:0]  now;
    logic [TICK_W-1:0]  lim;
  } smp_t;

endpackage

### rtl/touch_region_button_events.sv
// ----------------------------------------------------------------------------
// touch_region_button_events
// Turns touch samples into press, release and long-press events for up to
// NUM_BUTTONS rectangular regions, and answers flag and level queries.
//
//   channel  direction  handshake            word
//   in_      input      in_valid / in_stall  opcode, index, touch, ticks
//   out_     output     out_valid/out_stall  answer, levels
//   apb      config     psel/penable/pready  64-bit region / count regs
//
// One word per cycle while the output is not stalled.
// Per-button compares and flag update sit between the input register and
// the output register. Stall on the output holds the output register and
// backs up into the input register; in_stall follows out_stall combinationally.
// Reset clears the valid flags, config registers and all button state; the
// payload registers are not reset; no clearing pass.
// ----------------------------------------------------------------------------
module touch_region_button_events import trbe_pkg::*; #(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_opcode,
  input  logic [1:0]          in_button_index,
  input  logic                in_touch_down,
  input  logic [15:0]         in_touch_x,
  input  logic [15:0]         in_touch_y,
  input  logic [31:0]         in_now_ticks,
  input  logic [31:0]         in_long_press_ticks,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_answer,
  output logic [3:0]          out_levels,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  localparam int LIVE_MAX_I = (NUM_BUTTONS < REGION_REGS) ? NUM_BUTTONS : REGION_REGS;
  localparam logic [BTN_IDX_W-1:0] LIVE_MAX = BTN_IDX_W'(LIVE_MAX_I);

  logic [REGION_W-1:0]  region_r [REGION_REGS];
  logic [BTN_IDX_W-1:0] active_r;

  logic               s1_valid_r;
  logic [2:0]         s1_opcode_r;
  logic [1:0]         s1_index_r;
  smp_t               s1_smp_r;

  logic               out_valid_r;
  logic               answer_r;
  logic [LEVELS_W-1:0] levels_r;

  logic               wr_en;
  logic [2:0]         wr_idx;
  logic [BTN_IDX_W-1:0] live_cnt, new_live;
  logic               out_free;
  logic               s1_adv;
  logic               in_take;

  logic [NUM_BUTTONS-1:0] btn_active;
  logic [NUM_BUTTONS-1:0] btn_level;
  logic [NUM_BUTTONS-1:0] btn_answer;
  logic [LEVELS_W-1:0]    levels_nxt;

  assign pready   = 1'b1;
  assign wr_en    = psel & penable & pwrite & pready;
  assign wr_idx   = paddr[5:3];
  assign live_cnt = (active_r > LIVE_MAX) ? LIVE_MAX : active_r;
  assign new_live = (pwdata[2:0] > LIVE_MAX) ? LIVE_MAX : pwdata[2:0];

  always_comb begin
    prdata = '0;
    if (wr_idx == REG_ACTIVE) begin
      prdata = {{(DATA_W-BTN_IDX_W){1'b0}}, active_r};
    end else if (wr_idx < REG_ACTIVE) begin
      prdata = region_r[wr_idx[1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REGION_REGS; i++) begin
        region_r[i] <= '0;
      end
      active_r <= '0;
    end else if (wr_en) begin
      if (wr_idx == REG_ACTIVE) begin
        active_r <= pwdata[2:0];
      end else if (wr_idx < REG_ACTIVE) begin
        region_r[wr_idx[1:0]] <= pwdata;
      end
    end
  end

  // two-stage flow: input register, then output register
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_opcode_r   <= in_opcode;
      s1_index_r    <= in_button_index;
      s1_smp_r.down <= in_touch_down;
      s1_smp_r.x    <= in_touch_x;
      s1_smp_r.y    <= in_touch_y;
      s1_smp_r.now  <= in_now_ticks;
      s1_smp_r.lim  <= in_long_press_ticks;
    end
  end

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
    btn_ctl_t            ctl;
    logic [REGION_W-1:0] reg_i;

    if (i < REGION_REGS) begin : g_reg
      assign reg_i = region_r[i];
    end else begin : g_noreg
      assign reg_i = '0;
    end

    assign btn_active[i] = BTN_IDX_W'(i) < live_cnt;
    assign ctl.step   = s1_adv;
    assign ctl.active = btn_active[i];
    assign ctl.sel    = {1'b0, s1_index_r} == BTN_IDX_W'(i);
    assign ctl.clear  = wr_en && (wr_idx == REG_ACTIVE) && (BTN_IDX_W'(i) >= new_live);
    assign ctl.op     = op_t'(s1_opcode_r);

    trbe_button u_btn (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .smp       (s1_smp_r),
      .region    (reg_i),
      .level_nxt (btn_level[i]),
      .answer    (btn_answer[i])
    );
  end

  for (genvar i = 0; i < LEVELS_W; i++) begin : g_lv
    if (i < NUM_BUTTONS) begin : g_on
      assign levels_nxt[i] = btn_level[i] & btn_active[i];
    end else begin : g_off
      assign levels_nxt[i] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      answer_r <= |btn_answer;
      levels_r <= levels_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_answer = answer_r;
  assign out_levels = levels_r;

`ifndef ASSERT_OFF
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty input register");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && s1_valid_r) |-> s1_adv)
    else $error("input register overwritten before it moved on");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("output word appeared without an input word");
`endif

endmodule

### rtl/trbe_button.sv
// ----------------------------------------------------------------------------
// trbe_button
// State and event logic of one button region: level, sticky flags,
// press time stamp and long-press limit.
// ----------------------------------------------------------------------------
module trbe_button import trbe_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  btn_ctl_t            ctl,
  input  smp_t                smp,
  input  logic [REGION_W-1:0] region,
  output logic                level_nxt,
  output logic                answer
);

  logic              level_r;
  logic [2:0]        flags_r, flags_nxt;
  logic [TICK_W-1:0] stamp_r, stamp_nxt;
  logic [TICK_W-1:0] limit_r, limit_nxt;

  logic [COORD_W-1:0] rx, ry, rw, rh;
  logic [COORD_W:0]   x_hi, y_hi;
  logic               hit;
  logic               v;
  logic [TICK_W-1:0]  held;
  logic               is_long;

  assign rx   = region[15:0];
  assign ry   = region[31:16];
  assign rw   = region[47:32];
  assign rh   = region[63:48];
  assign x_hi = {1'b0, rx} + {1'b0, rw};
  assign y_hi = {1'b0, ry} + {1'b0, rh};
  assign hit  = (smp.x >= rx) && ({1'b0, smp.x} <= x_hi) &&
                (smp.y >= ry) && ({1'b0, smp.y} <= y_hi);
  assign v       = smp.down & hit;
  assign held    = smp.now - stamp_r;
  assign is_long = (limit_r != '0) && (held > limit_r);

  always_comb begin
    level_nxt = level_r;
    flags_nxt = flags_r;
    stamp_nxt = stamp_r;
    limit_nxt = limit_r;
    answer    = 1'b0;
    if (ctl.clear) begin
      level_nxt = 1'b0;
      flags_nxt = '0;
      stamp_nxt = '0;
      limit_nxt = '0;
    end else if (ctl.step && ctl.active) begin
      case (ctl.op)
        OP_SAMPLE: begin
          if (v != level_r) begin
            if (v) begin
              flags_nxt[FLAG_PRESS] = 1'b1;
              stamp_nxt             = smp.now;
            end else if (is_long) begin
              flags_nxt[FLAG_LONG] = 1'b1;
            end else begin
              flags_nxt[FLAG_RELEASE] = 1'b1;
            end
            level_nxt = v;
          end
        end
        OP_PRESSED: begin
          if (ctl.sel) begin
            answer                = flags_r[FLAG_PRESS];
            flags_nxt[FLAG_PRESS] = 1'b0;
          end
        end
        OP_RELEASD: begin
          if (ctl.sel) begin
            answer                  = flags_r[FLAG_RELEASE];
            flags_nxt[FLAG_RELEASE] = 1'b0;
          end
        end
        OP_LONG: begin
          if (ctl.sel) begin
            limit_nxt            = smp.lim;
            answer               = flags_r[FLAG_LONG];
            flags_nxt[FLAG_LONG] = 1'b0;
          end
        end
        OP_LEVEL: begin
          if (ctl.sel) begin
            answer = level_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= 1'b0;
      flags_r <= '0;
      stamp_r <= '0;
      limit_r <= '0;
    end else begin
      level_r <= level_nxt;
      flags_r <= flags_nxt;
      stamp_r <= stamp_nxt;
      limit_r <= limit_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_idle_level: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.active |-> !level_r)
    else $error("inactive button holds a level");

  a_idle_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.active |-> (flags_r == '0) && (limit_r == '0))
    else $error("inactive button holds flags or limit");

  a_answer_step: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.step |-> !answer)
    else $error("answer raised without a word");
`endif

endmodule

### test/tb_touch_region_button_events.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_touch_region_button_events
// Self-checking bench for the touch region button event block. A scoreboard
// class keeps its own copy of the region registers and of every button's
// level, flags, press stamp and long-press limit. It predicts one result word
// per accepted input word and checks the output stream in order. A directed
// pass covers region corners, wrapping ticks, long presses, inactive buttons
// and unknown codes. Random phases follow, each with its own region setup,
// button count, sender bursts and receiver stall pattern.
// ----------------------------------------------------------------------------
module tb_touch_region_button_events;
  import trbe_pkg::*;

  localparam int TIMEOUT_NS      = 1000000;
  localparam int PHASE_WORDS     = 225;
  localparam int OP_FIRST_UNUSED = int'(OP_LEVEL) + 1;
  localparam int OP_LAST_CODE    = 7;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [1:0]  index;
    logic        down;
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] now;
    logic [31:0] lim;
  } touch_word_t;

  typedef struct packed {
    logic       answer;
    logic [3:0] levels;
  } button_result_t;

  class button_event_scoreboard;
    logic [REGION_W-1:0] region [REGION_REGS];
    logic [2:0]          active;
    logic                level  [NUM_BUTTONS_DEF];
    logic [2:0]          flags  [NUM_BUTTONS_DEF];
    logic [TICK_W-1:0]   stamp  [NUM_BUTTONS_DEF];
    logic [TICK_W-1:0]   limit  [NUM_BUTTONS_DEF];
    button_result_t      expected_q [$];
    int                  errors;

    function new();
      active = '0;
      errors = 0;
      for (int i = 0; i < REGION_REGS; i++) region[i] = '0;
      for (int i = 0; i < NUM_BUTTONS_DEF; i++) clear_button(i);
    endfunction

    function void clear_button(int b);
      level[b] = 1'b0;
      flags[b] = '0;
      stamp[b] = '0;
      limit[b] = '0;
    endfunction

    function int live_count();
      int n;
      n = active;
      if (n > NUM_BUTTONS_DEF) n = NUM_BUTTONS_DEF;
      if (n > REGION_REGS) n = REGION_REGS;
      return n;
    endfunction

    // 17-bit edges so x+w and y+h never wrap
    function logic hit_region(int b, logic [15:0] tx, logic [15:0] ty);
      logic [16:0] rx, ry, rw, rh;
      rx = {1'b0, region[b][15:0]};
      ry = {1'b0, region[b][31:16]};
      rw = {1'b0, region[b][47:32]};
      rh = {1'b0, region[b][63:48]};
      return ({1'b0, tx} >= rx) && ({1'b0, tx} <= rx + rw) &&
             ({1'b0, ty} >= ry) && ({1'b0, ty} <= ry + rh);
    endfunction

    function void write_reg(int idx, logic [63:0] val);
      if (idx < REGION_REGS) begin
        region[idx] = val;
      end else if (idx == int'(REG_ACTIVE)) begin
        active = val[2:0];
        for (int i = live_count(); i < NUM_BUTTONS_DEF; i++) clear_button(i);
      end
    endfunction

    function logic take_flag(int b, int pos);
      logic r;
      r = flags[b][pos];
      flags[b][pos] = 1'b0;
      return r;
    endfunction

    function void note_word(touch_word_t w);
      logic           v;
      int             n;
      button_result_t r;
      n = live_count();
      r.answer = 1'b0;
      r.levels = '0;
      if (w.opcode == OP_SAMPLE) begin
        for (int i = 0; i < n; i++) begin
          v = w.down & hit_region(i, w.x, w.y);
          if (v != level[i]) begin
            if (v) begin
              flags[i][FLAG_PRESS] = 1'b1;
              stamp[i] = w.now;
            end else if (limit[i] != '0 && (w.now - stamp[i]) > limit[i]) begin
              flags[i][FLAG_LONG] = 1'b1;
            end else begin
              flags[i][FLAG_RELEASE] = 1'b1;
            end
            level[i] = v;
          end
        end
      end else if (int'(w.index) < n) begin
        case (w.opcode)
          OP_PRESSED: r.answer = take_flag(w.index, FLAG_PRESS);
          OP_RELEASD: r.answer = take_flag(w.index, FLAG_RELEASE);
          OP_LONG: begin
            limit[w.index] = w.lim;
            r.answer = take_flag(w.index, FLAG_LONG);
          end
          OP_LEVEL: r.answer = level[w.index];
          default: ;
        endcase
      end
      for (int i = 0; i < n; i++) r.levels[i] = level[i];
      expected_q.push_back(r);
    endfunction

    function void check_result(logic answer, logic [3:0] levels);
      button_result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: answer %0b levels %h", $time, answer, levels);
        return;
      end
      e = expected_q.pop_front();
      if (answer !== e.answer) begin
        errors++;
        $display("%0t: answer mismatch: expected %0b actual %0b", $time, e.answer, answer);
      end
      if (levels !== e.levels) begin
        errors++;
        $display("%0t: levels mismatch: expected %h actual %h", $time, e.levels, levels);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [2:0]        in_opcode;
  logic [1:0]        in_button_index;
  logic              in_touch_down;
  logic [15:0]       in_touch_x;
  logic [15:0]       in_touch_y;
  logic [31:0]       in_now_ticks;
  logic [31:0]       in_long_press_ticks;
  logic              out_valid;
  logic              out_stall;
  logic              out_answer;
  logic [3:0]        out_levels;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  button_event_scoreboard sb;
  int                     stall_pct  = 0;
  int                     burst_left = 1;
  bit                     gaps_on    = 1'b0;
  logic [31:0]            tick_now   = '0;

  touch_region_button_events #(
    .NUM_BUTTONS(NUM_BUTTONS_DEF)
  ) DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_button_index     (in_button_index),
    .in_touch_down       (in_touch_down),
    .in_touch_x          (in_touch_x),
    .in_touch_y          (in_touch_y),
    .in_now_ticks        (in_now_ticks),
    .in_long_press_ticks (in_long_press_ticks),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_answer          (out_answer),
    .out_levels          (out_levels),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: stall runs of random length, density set per phase
  initial begin
    int run;
    run = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (run > 0) begin
        run--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
        run = $urandom_range(0, 5);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_result(out_answer, out_levels);
  end

  function automatic touch_word_t mk_sample(logic down, logic [15:0] x, logic [15:0] y,
                                            logic [31:0] now);
    touch_word_t w;
    w.opcode = OP_SAMPLE;
    w.index  = 2'($urandom);
    w.down   = down;
    w.x      = x;
    w.y      = y;
    w.now    = now;
    w.lim    = $urandom;
    return w;
  endfunction

  function automatic touch_word_t mk_query(logic [2:0] op, int idx, logic [31:0] lim);
    touch_word_t w;
    w.opcode = op;
    w.index  = 2'(idx);
    w.down   = 1'($urandom);
    w.x      = 16'($urandom);
    w.y      = 16'($urandom);
    w.now    = $urandom;
    w.lim    = lim;
    return w;
  endfunction

  function automatic logic [15:0] coord_near(logic [15:0] lo, logic [15:0] span);
    case ($urandom_range(0, 5))
      0: return lo - 16'd1;
      1: return lo;
      2: return lo + span;
      3: return lo + span + 16'd1;
      default: return lo + 16'($urandom_range(0, span));
    endcase
  endfunction

  function automatic logic [63:0] rand_region();
    logic [15:0] rx, ry, rw, rh;
    if ($urandom_range(0, 7) == 0) return {$urandom, $urandom};
    rx = 16'($urandom);
    ry = 16'($urandom);
    rw = 16'($urandom_range(0, 400));
    rh = 16'($urandom_range(0, 400));
    return {rh, rw, ry, rx};
  endfunction

  function automatic touch_word_t rand_word();
    touch_word_t w;
    int          pick, b;
    logic [63:0] r;
    logic [31:0] lim;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      tick_now += 32'($urandom_range(0, 40));
      if ($urandom_range(0, 49) == 0) tick_now = $urandom;
      w = mk_sample(($urandom_range(0, 3) != 0), 16'($urandom), 16'($urandom), tick_now);
      if ($urandom_range(0, 9) < 7) begin
        b = $urandom_range(0, REGION_REGS - 1);
        r = sb.region[b];
        w.x = coord_near(r[15:0], r[47:32]);
        w.y = coord_near(r[31:16], r[63:48]);
      end
    end else if (pick < 95) begin
      case ($urandom_range(0, 9))
        0:       lim = '0;
        1:       lim = $urandom;
        default: lim = 32'($urandom_range(1, 60));
      endcase
      w = mk_query(3'($urandom_range(int'(OP_PRESSED), int'(OP_LEVEL))),
                   $urandom_range(0, 3), lim);
    end else begin
      w = mk_query(3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE)),
                   $urandom_range(0, 3), $urandom);
    end
    return w;
  endfunction

  task automatic send_word(touch_word_t w);
    in_valid            <= 1'b1;
    in_opcode           <= w.opcode;
    in_button_index     <= w.index;
    in_touch_down       <= w.down;
    in_touch_x          <= w.x;
    in_touch_y          <= w.y;
    in_now_ticks        <= w.now;
    in_long_press_ticks <= w.lim;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_word(w);
    if (gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(1, 20);
      end
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(int idx, logic [63:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * 8);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.write_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int phase_active [8];
    sb = new();
    phase_active = '{4, 7, 2, 0, 4, 1, 5, 3};
    rst_n               <= 1'b0;
    in_valid            <= 1'b0;
    in_opcode           <= OP_SAMPLE;
    in_button_index     <= '0;
    in_touch_down       <= 1'b0;
    in_touch_x          <= '0;
    in_touch_y          <= '0;
    in_now_ticks        <= '0;
    in_long_press_ticks <= '0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: corners, wrap, long press, inactive buttons, unknown codes
    reg_write(0, {16'd30, 16'd50, 16'd200, 16'd100});
    reg_write(1, {64{1'b1}});
    reg_write(2, '0);
    reg_write(3, {16'hFFFF, 16'hFFFF, 16'd0, 16'd0});
    reg_write(int'(REG_ACTIVE), 64'd4);
    gaps_on   = 1'b1;
    stall_pct = 30;
    send_word(mk_query(OP_LONG, 0, 32'd10));
    send_word(mk_sample(1'b1, 16'd100, 16'd200, 32'd1000));
    send_word(mk_query(OP_PRESSED, 0, '0));
    send_word(mk_query(OP_PRESSED, 0, '0));
    send_word(mk_query(OP_LEVEL, 0, '0));
    send_word(mk_sample(1'b1, 16'd150, 16'd230, 32'd1005));
    send_word(mk_sample(1'b1, 16'd151, 16'd230, 32'd1020));
    send_word(mk_query(OP_LONG, 0, '0));
    send_word(mk_query(OP_RELEASD, 0, '0));
    send_word(mk_sample(1'b1, 16'd0, 16'd0, 32'd0));
    send_word(mk_sample(1'b0, 16'hFFFF, 16'hFFFF, 32'd5));
    send_word(mk_query(OP_RELEASD, 2, '0));
    send_word(mk_query(OP_PRESSED, 2, '0));
    send_word(mk_sample(1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFF0));
    send_word(mk_query(OP_LONG, 1, 32'd16));
    send_word(mk_sample(1'b0, 16'd0, 16'd0, 32'd5));
    send_word(mk_query(OP_LONG, 1, 32'hFFFF_FFFF));
    send_word(mk_query(OP_LEVEL, 3, '0));
    for (int op = OP_FIRST_UNUSED; op <= OP_LAST_CODE; op++)
      send_word(mk_query(3'(op), 0, $urandom));
    wait_idle();
    reg_write(int'(REG_ACTIVE), 64'd2);
    send_word(mk_query(OP_LONG, 3, 32'd5));
    send_word(mk_query(OP_LEVEL, 3, '0));
    wait_idle();
    reg_write(int'(REG_ACTIVE), 64'd7);
    send_word(mk_query(OP_PRESSED, 3, '0));
    wait_idle();
    reg_write(int'(REG_ACTIVE) + 1, {64{1'b1}});
    reg_write(int'(REG_ACTIVE), 64'd0);
    send_word(mk_sample(1'b1, 16'd10, 16'd10, 32'd100));
    send_word(mk_query(OP_LEVEL, 0, '0));

    // random phases
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      for (int i = 0; i < REGION_REGS; i++) reg_write(i, rand_region());
      reg_write(int'(REG_ACTIVE), 64'(phase_active[p]));
      case (p % 4)
        0: begin stall_pct = 0;  gaps_on = 1'b0; end
        1: begin stall_pct = 25; gaps_on = 1'b1; end
        2: begin stall_pct = 60; gaps_on = 1'b1; end
        default: begin stall_pct = 10; gaps_on = 1'b0; end
      endcase
      for (int k = 0; k < PHASE_WORDS; k++) send_word(rand_word());
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_touch_region_button_events: PASS");
    end else begin
      $display("tb_touch_region_button_events: FAIL");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_touch_region_button_events: FAIL");
    $finish;
  end

endmodule
